### design/block_reverse_k_group_defines.svh
// Assertion helpers used by the file that checks the group reversal logic.
`ifndef BLOCK_REVERSE_K_GROUP_DEFINES_SVH
`define BLOCK_REVERSE_K_GROUP_DEFINES_SVH

// Checked only while out of reset.
`define BRKG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BRKG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### design/brkg_pkg.sv
package brkg_pkg;

    // Item value width and group size register width
    localparam int VALUE_W   = 32;
    localparam int CFG_W     = 5;
    localparam int MAX_GROUP = 16;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1);

    // Shift controls for the row of storage cells
    typedef struct packed {
        logic push;   // shift toward higher cells, new item into cell 0
        logic pop;    // shift toward cell 0
    } t_shift_ctl;

endpackage

### design/brkg_cell.sv
module brkg_cell (
    input  logic                              i_clk,
    input  brkg_pkg::t_shift_ctl              i_ctl,
    input  logic [brkg_pkg::VALUE_W-1:0]      i_from_left,
    input  logic [brkg_pkg::VALUE_W-1:0]      i_from_right,
    output logic [brkg_pkg::VALUE_W-1:0]      o_value
);

    logic [brkg_pkg::VALUE_W-1:0] r_value;

    // One held item; takes the neighbor's item on a shift
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_value <= i_from_left;
        end else if (i_ctl.pop) begin
            r_value <= i_from_right;
        end
    end

    assign o_value = r_value;

endmodule

### design/brkg_chain.sv
module brkg_chain #(
    parameter int MAX_GROUP = brkg_pkg::MAX_GROUP,
    parameter int IW        = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
    input  logic                              i_clk,
    input  brkg_pkg::t_shift_ctl              i_ctl,
    input  logic [brkg_pkg::VALUE_W-1:0]      i_push_value,
    input  logic [IW-1:0]                     i_sel,
    output logic [brkg_pkg::VALUE_W-1:0]      o_head,
    output logic [brkg_pkg::VALUE_W-1:0]      o_sel_value
);

    logic [brkg_pkg::VALUE_W-1:0] w_cell [MAX_GROUP];

    // Row of cells: cell 0 holds the newest item, cell n-1 the oldest
    for (genvar g = 0; g < MAX_GROUP; g++) begin : g_cell
        logic [brkg_pkg::VALUE_W-1:0] w_left;
        logic [brkg_pkg::VALUE_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = i_push_value;
        end else begin : g_inner
            assign w_left = w_cell[g-1];
        end

        if (g == MAX_GROUP - 1) begin : g_last
            assign w_right = w_cell[g];
        end else begin : g_mid
            assign w_right = w_cell[g+1];
        end

        brkg_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (i_ctl),
            .i_from_left  (w_left),
            .i_from_right (w_right),
            .o_value      (w_cell[g])
        );
    end

    assign o_head      = w_cell[0];
    assign o_sel_value = w_cell[i_sel];

endmodule

### design/block_reverse_k_group.sv
// Reverses a stream of signed 32-bit items in groups of group_size (1..MAX_GROUP; 0 acts as 1,
// larger values act as MAX_GROUP). Items are pushed into a row of cells; when a group is full
// it is sent newest first, and when tlast arrives on a short group the held items are sent
// oldest first. Intake stops while a burst drains: the cell row delivers one result per cycle
// while m_axis_tready accepts them, and intake resumes once the burst has left. m_axis_tlast
// marks the last result of a burst, m_axis_tuser marks the end of the whole sequence.
// group_size must be written only while the block is idle, a rule on the user that the block
// itself leaves unenforced.
`include "block_reverse_k_group_defines.svh"

module block_reverse_k_group #(
    parameter int MAX_GROUP = brkg_pkg::MAX_GROUP
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // group size register write
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [brkg_pkg::CFG_W-1:0]          i_cfg_data,
    // input items
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [brkg_pkg::VALUE_W-1:0]        s_axis_tdata,  // [31:0] value
    input  logic                                s_axis_tlast,  // final_item
    // results
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [brkg_pkg::VALUE_W-1:0]        m_axis_tdata,  // [31:0] out_value
    output logic                                m_axis_tlast,  // run_end
    output logic                                m_axis_tuser   // sequence_end
);

    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

    typedef enum logic [2:0] {
        S_COLLECT = 3'b001,
        S_REVERSE = 3'b010,
        S_FORWARD = 3'b100
    } t_state;

    t_state                         r_state, n_state;
    logic [CW-1:0]                  r_cnt, n_cnt;
    logic                           r_fin, n_fin;
    logic [brkg_pkg::CFG_W-1:0]     r_cfg;
    logic                           r_o_valid;
    logic [brkg_pkg::VALUE_W-1:0]   r_o_data;
    logic                           r_o_last;
    logic                           r_o_seq;

    logic [CW-1:0]                  w_k;
    logic [CW-1:0]                  w_cnt_inc;
    logic                           w_in_xfer;
    logic                           w_emit;
    logic                           w_emit_last;
    brkg_pkg::t_shift_ctl           w_ctl;
    logic [brkg_pkg::VALUE_W-1:0]   w_head;
    logic [brkg_pkg::VALUE_W-1:0]   w_sel_value;

    // Group size register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= brkg_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    // Effective group size, clamped to 1..MAX_GROUP
    always_comb begin
        if (r_cfg == '0) begin
            w_k = CW'(1);
        end else if (32'(r_cfg) > 32'(MAX_GROUP)) begin
            w_k = CW'(MAX_GROUP);
        end else begin
            w_k = CW'(r_cfg);
        end
    end

    assign s_axis_tready = (r_state == S_COLLECT);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_cnt_inc     = r_cnt + CW'(1);
    assign w_emit        = (r_state != S_COLLECT) && (!r_o_valid || m_axis_tready);
    assign w_emit_last   = (r_cnt == CW'(1));

    // Cell row shifts: push on intake, pop while a reversed group drains
    assign w_ctl.push = w_in_xfer;
    assign w_ctl.pop  = w_emit && (r_state == S_REVERSE);

    brkg_chain #(
        .MAX_GROUP (MAX_GROUP),
        .IW        (IW)
    ) u_chain (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_push_value (s_axis_tdata),
        .i_sel        (IW'(r_cnt - CW'(1))),
        .o_head       (w_head),
        .o_sel_value  (w_sel_value)
    );

    // Sequencer: collect, then drain a group reversed or in arrival order
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_fin   = r_fin;
        unique case (r_state)
            S_COLLECT: begin
                if (w_in_xfer) begin
                    n_cnt = w_cnt_inc;
                    n_fin = s_axis_tlast;
                    if (w_cnt_inc >= w_k) begin
                        n_state = S_REVERSE;
                    end else if (s_axis_tlast) begin
                        n_state = S_FORWARD;
                    end
                end
            end
            S_REVERSE, S_FORWARD: begin
                if (w_emit) begin
                    n_cnt = r_cnt - CW'(1);
                    if (w_emit_last) begin
                        n_state = S_COLLECT;
                    end
                end
            end
            default: begin
                n_state = S_COLLECT;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
            r_cnt   <= '0;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_fin   <= n_fin;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_emit) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_data <= (r_state == S_REVERSE) ? w_head : w_sel_value;
            r_o_last <= w_emit_last;
            r_o_seq  <= w_emit_last && r_fin;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tuser  = r_o_seq;

    // Checks
    `BRKG_ASSERT(a_drain_nonempty, (r_state != S_COLLECT) |-> (r_cnt != '0), "drain with no items held")
    `BRKG_ASSERT(a_collect_room, (r_state == S_COLLECT) |-> (32'(r_cnt) < 32'(MAX_GROUP)), "cell row full while collecting")
    `BRKG_ASSERT(a_seq_on_last, (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast, "sequence end off a run end")
    `BRKG_ASSERT_ALWAYS(a_no_intake_drain, (s_axis_tready && i_rst_n) |-> (r_state == S_COLLECT), "intake while draining")

endmodule

### tb/tb_block_reverse_k_group.sv
module tb_block_reverse_k_group;

    localparam int VW          = brkg_pkg::VALUE_W;
    localparam int GW          = brkg_pkg::CFG_W;
    localparam int DEPTH       = brkg_pkg::MAX_GROUP;
    localparam int STALL_LIMIT = 1000;
    localparam int IDLE_PCT    = 32;
    localparam int DRAIN_WAIT  = 40;
    localparam int RANDOM_ITEMS = 80;

    // one reordered output item
    typedef struct packed {
        logic [VW-1:0] value;
        logic          run_end;
        logic          seq_end;
    } t_reordered;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [GW-1:0] i_cfg_data = '0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [VW-1:0] s_axis_tdata = '0;   // [31:0] value
    logic          s_axis_tlast = 1'b0; // final_item
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [VW-1:0] m_axis_tdata;        // [31:0] out_value
    logic          m_axis_tlast;        // run_end
    logic          m_axis_tuser;        // sequence_end

    // shadow state of the group buffer
    logic [VW-1:0] held_vals [DEPTH];
    int            held_cnt = 0;
    logic [GW-1:0] group_reg = brkg_pkg::CFG_RESET;

    t_reordered    reordered_q[$];
    int            errors_seen = 0;
    int            stall_cycles = 0;
    bit            steady = 1'b0;

    block_reverse_k_group i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Buffer one accepted item and queue the burst it releases, if any
    function automatic void regroup_item(logic [VW-1:0] v, logic fin);
        int k;
        int n;
        k = (group_reg == 0) ? 1 : ((group_reg > DEPTH) ? DEPTH : int'(group_reg));
        if (held_cnt < DEPTH) begin
            held_vals[held_cnt] = v;
            held_cnt++;
        end
        n = held_cnt;
        if (n >= k) begin
            // complete group: newest first
            for (int i = 0; i < n; i++)
                reordered_q.push_back('{held_vals[n-1-i], i == n-1, (i == n-1) && fin});
            held_cnt = 0;
        end else if (fin) begin
            // short group closed by the final item: arrival order
            for (int i = 0; i < n; i++)
                reordered_q.push_back('{held_vals[i], i == n-1, i == n-1});
            held_cnt = 0;
        end
    endfunction

    // Present one item, with an optional random gap, and wait for its transfer
    task automatic send_item(logic [VW-1:0] v, logic fin);
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        regroup_item(v, fin);
    endtask

    // Drop the input valid and wait until every queued result has left
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (reordered_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_group_size(logic [GW-1:0] g);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= g;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        group_reg = g;
    endtask

    // Reset value of one: extremes pass straight through
    task automatic test_pass_through();
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b1);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b1);
    endtask

    // Zero acts as one
    task automatic test_group_size_zero();
        write_group_size(5'd0);
        send_item(32'h1234_5678, 1'b0);
        send_item(32'hA5A5_5A5A, 1'b1);
    endtask

    // Full groups reversed, the second completed by the final item
    task automatic test_full_groups();
        write_group_size(5'd4);
        for (int i = 0; i < 4; i++) send_item(32'h0000_0010 + i, 1'b0);
        for (int i = 0; i < 4; i++) send_item(32'hF000_0000 + i, i == 3);
    endtask

    // Short group closed by the final item keeps arrival order
    task automatic test_short_final();
        write_group_size(5'd5);
        send_item(32'h0000_0001, 1'b0);
        send_item(32'h8000_0001, 1'b0);
        send_item(32'h7FFF_FFFE, 1'b1);
    endtask

    // Group size lowered below the held count flushes everything reversed
    task automatic test_lowered_mid_group();
        write_group_size(5'd8);
        for (int i = 0; i < 3; i++) send_item(32'hC0DE_0000 + i, 1'b0);
        write_group_size(5'd2);
        send_item(32'hC0DE_00FF, 1'b0);
    endtask

    // Random sequences over several group sizes, extremes included
    task automatic test_random_phases();
        logic [GW-1:0] sizes [8];
        int sent;
        int phase;
        int len;
        sizes = '{5'd16, 5'd31, 5'd3, 5'd1, 5'd17, 5'd0, 5'd7, 5'd0};
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            write_group_size((phase < 6) ? sizes[phase] : GW'($urandom_range(31)));
            steady = (phase == 2);
            len = $urandom_range(12, 20);
            for (int i = 0; i < len; i++) begin
                // mostly well-formed runs, occasional early sequence ends
                send_item($urandom, $urandom_range(99) < 12);
            end
            sent += len;
            phase++;
        end
        steady = 1'b0;
    endtask

    // Result sink ready
    always @(posedge i_clk) begin
        m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_reordered want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (reordered_q.size() == 0) begin
                $error("unexpected result: out_value %h", m_axis_tdata);
                errors_seen++;
            end else begin
                want = reordered_q.pop_front();
                if (m_axis_tdata !== want.value) begin
                    $error("out_value: expected %h, got %h", want.value, m_axis_tdata);
                    errors_seen++;
                end
                if (m_axis_tlast !== want.run_end) begin
                    $error("run_end: expected %b, got %b", want.run_end, m_axis_tlast);
                    errors_seen++;
                end
                if (m_axis_tuser !== want.seq_end) begin
                    $error("sequence_end: expected %b, got %b", want.seq_end, m_axis_tuser);
                    errors_seen++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_block_reverse_k_group: errors");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_pass_through();
        test_group_size_zero();
        test_full_groups();
        test_short_final();
        test_lowered_mid_group();
        test_random_phases();
        wait_idle();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors_seen == 0 && reordered_q.size() == 0) begin
            $display("tb_block_reverse_k_group: clean");
        end else begin
            $display("tb_block_reverse_k_group: errors");
        end
        $finish;
    end

endmodule
